[hw/rtl/fss_pkg.sv]
package fss_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned VAL_W    = 30;
  localparam int unsigned POS_O_W  = 11;
  localparam int unsigned AW       = $clog2(CAPACITY);
  localparam int unsigned CW       = AW + 1;
  localparam int unsigned KEY_W    = VAL_W + AW;
  localparam int unsigned SUM_W    = VAL_W + 2;
  localparam int unsigned UW       = (KEY_W > SUM_W) ? KEY_W : SUM_W;
  localparam int unsigned PW       = (AW + 1 > POS_O_W) ? AW + 1 : POS_O_W;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  function automatic logic [POS_O_W-1:0] pos_out(input logic [AW-1:0] p);
    logic [PW-1:0] t;
    t = PW'(p) + PW'(1);
    return t[POS_O_W-1:0];
  endfunction

endpackage

[hw/rtl/four_sum_index_search.sv]
// Four-sum search. Values load one item per cycle into a store of CAPACITY
// entries (extra items are dropped and flagged). The item marked last starts
// the search; the input stalls until the result is registered. A rank sort
// orders the entries by (value, position), then a scan over pairs (a, b)
// with a two-pointer sweep over (c, d) finds the lexicographically smallest
// matching quadruple. The four-value sums and most key compares go through
// one shared adder/compare unit, and each store has one read port.
module four_sum_index_search import fss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [VAL_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VAL_W-1:0]     value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [POS_O_W-1:0]   first_pos_o,
  output logic [POS_O_W-1:0]   second_pos_o,
  output logic [POS_O_W-1:0]   third_pos_o,
  output logic [POS_O_W-1:0]   fourth_pos_o,
  output logic                 overflowed_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RI     = 5'd1;
  localparam logic [4:0] S_RI2    = 5'd2;
  localparam logic [4:0] S_RJ     = 5'd3;
  localparam logic [4:0] S_RJ2    = 5'd4;
  localparam logic [4:0] S_A_LD   = 5'd5;
  localparam logic [4:0] S_A_CAP  = 5'd6;
  localparam logic [4:0] S_B_LD   = 5'd7;
  localparam logic [4:0] S_B_CAP  = 5'd8;
  localparam logic [4:0] S_C_LD   = 5'd9;
  localparam logic [4:0] S_C_CAP  = 5'd10;
  localparam logic [4:0] S_D_LD   = 5'd11;
  localparam logic [4:0] S_D_CAP  = 5'd12;
  localparam logic [4:0] S_TEST   = 5'd13;
  localparam logic [4:0] S_DW_LD  = 5'd14;
  localparam logic [4:0] S_DW_CAP = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;

  logic [4:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             hit_q, hit_d;
  logic             need_d_q, need_d_d;
  logic [VAL_W-1:0] target_q;
  logic [CW-1:0]    i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [CW-1:0]    a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [KEY_W-1:0] ki_q, ki_d;
  logic [KEY_W-1:0] ka_q, ka_d, kb_q, kb_d, kc_q, kc_d, kd_q, kd_d;

  logic             out_valid_q;
  logic             found_q;
  logic [POS_O_W-1:0] p0_q, p1_q, p2_q, p3_q;
  logic             ovf_out_q;

  logic             accept, out_free;
  logic             st_we;
  logic [AW-1:0]    st_raddr, so_raddr;
  logic [KEY_W-1:0] st_rdata, so_rdata;
  logic             so_we;
  logic [UW-1:0]    op0, op1, op2, op3, rhs;
  cmp_res_t         cmp;
  logic             nb_ok, na_ok;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign st_we      = accept && (cnt_q < CW'(CAPACITY));
  assign so_we      = (state_q == S_RJ2) && (j_q + CW'(1) == cnt_q);
  assign nb_ok      = (b_q + CW'(3)) < cnt_q;
  assign na_ok      = (a_q + CW'(4)) < cnt_q;

  assign st_raddr = (state_q == S_RI) ? i_q[AW-1:0] : j_q[AW-1:0];

  always_comb begin
    case (state_q)
      S_A_LD:  so_raddr = a_q[AW-1:0];
      S_B_LD:  so_raddr = b_q[AW-1:0];
      S_C_LD:  so_raddr = c_q[AW-1:0];
      S_DW_LD: so_raddr = d_q[AW-1:0] - AW'(1);
      default: so_raddr = d_q[AW-1:0];
    endcase
  end

  fss_ram #(.Width(KEY_W), .Depth(CAPACITY)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({value_i, cnt_q[AW-1:0]}),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  fss_ram #(.Width(KEY_W), .Depth(CAPACITY)) u_sorted (
    .clk_i   (clk_i),
    .we_i    (so_we),
    .waddr_i (rank_q[AW-1:0] + AW'(st_rdata < ki_q)),
    .wdata_i (ki_q),
    .raddr_i (so_raddr),
    .rdata_o (so_rdata)
  );

  always_comb begin
    op0 = '0;
    op1 = '0;
    op2 = '0;
    op3 = '0;
    rhs = '0;
    case (state_q)
      S_TEST: begin
        op0 = UW'(ka_q[KEY_W-1:AW]);
        op1 = UW'(kb_q[KEY_W-1:AW]);
        op2 = UW'(kc_q[KEY_W-1:AW]);
        op3 = UW'(kd_q[KEY_W-1:AW]);
        rhs = UW'(target_q);
      end
      S_DW_CAP: begin
        op0 = UW'(so_rdata[KEY_W-1:AW]);
        rhs = UW'(kd_q[KEY_W-1:AW]);
      end
      default: begin
        op0 = UW'(st_rdata);
        rhs = UW'(ki_q);
      end
    endcase
  end

  fss_cmp u_cmp (
    .op0_i (op0),
    .op1_i (op1),
    .op2_i (op2),
    .op3_i (op3),
    .rhs_i (rhs),
    .res_o (cmp)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    hit_d    = hit_q;
    need_d_d = need_d_q;
    i_d      = i_q;
    j_d      = j_q;
    rank_d   = rank_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    d_d      = d_q;
    ki_d     = ki_q;
    ka_d     = ka_q;
    kb_d     = kb_q;
    kc_d     = kc_q;
    kd_d     = kd_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (st_we) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            hit_d = 1'b0;
            i_d   = '0;
            if (cnt_d < CW'(4)) begin
              state_d = S_FIN;
            end else begin
              state_d = S_RI;
            end
          end
        end
      end
      S_RI: state_d = S_RI2;
      S_RI2: begin
        ki_d    = st_rdata;
        j_d     = '0;
        rank_d  = '0;
        state_d = S_RJ;
      end
      S_RJ: state_d = S_RJ2;
      S_RJ2: begin
        if (cmp.lt) begin
          rank_d = rank_q + CW'(1);
        end
        j_d     = j_q + CW'(1);
        state_d = S_RJ;
        if (so_we) begin
          i_d = i_q + CW'(1);
          if (i_q + CW'(1) == cnt_q) begin
            a_d     = '0;
            state_d = S_A_LD;
          end else begin
            state_d = S_RI;
          end
        end
      end
      S_A_LD: state_d = S_A_CAP;
      S_A_CAP: begin
        ka_d    = so_rdata;
        b_d     = a_q + CW'(1);
        state_d = S_B_LD;
      end
      S_B_LD: state_d = S_B_CAP;
      S_B_CAP: begin
        kb_d     = so_rdata;
        c_d      = b_q + CW'(1);
        d_d      = cnt_q - CW'(1);
        need_d_d = 1'b1;
        state_d  = S_C_LD;
      end
      S_C_LD: state_d = S_C_CAP;
      S_C_CAP: begin
        kc_d    = so_rdata;
        state_d = need_d_q ? S_D_LD : S_TEST;
      end
      S_D_LD: state_d = S_D_CAP;
      S_D_CAP: begin
        kd_d     = so_rdata;
        need_d_d = 1'b0;
        state_d  = S_TEST;
      end
      S_TEST: begin
        if (cmp.eq) begin
          hit_d   = 1'b1;
          state_d = ((d_q - CW'(1)) > c_q) ? S_DW_LD : S_FIN;
        end else if ((cmp.lt && (c_q + CW'(1) < d_q)) ||
                     (!cmp.lt && (c_q < d_q - CW'(1)))) begin
          if (cmp.lt) begin
            c_d     = c_q + CW'(1);
            state_d = S_C_LD;
          end else begin
            d_d     = d_q - CW'(1);
            state_d = S_D_LD;
          end
        end else if (nb_ok) begin
          b_d     = b_q + CW'(1);
          state_d = S_B_LD;
        end else if (na_ok) begin
          a_d     = a_q + CW'(1);
          state_d = S_A_LD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DW_LD: state_d = S_DW_CAP;
      S_DW_CAP: begin
        if (cmp.eq) begin
          d_d     = d_q - CW'(1);
          kd_d    = so_rdata;
          state_d = ((d_q - CW'(2)) > c_q) ? S_DW_LD : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      hit_q       <= 1'b0;
      need_d_q    <= 1'b0;
      target_q    <= VAL_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      hit_q    <= hit_d;
      need_d_q <= need_d_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    rank_q <= rank_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    ki_q   <= ki_d;
    ka_q   <= ka_d;
    kb_q   <= kb_d;
    kc_q   <= kc_d;
    kd_q   <= kd_d;
    if (state_q == S_FIN && out_free) begin
      found_q   <= hit_q;
      ovf_out_q <= ovf_q;
      p0_q      <= hit_q ? pos_out(ka_q[AW-1:0]) : '0;
      p1_q      <= hit_q ? pos_out(kb_q[AW-1:0]) : '0;
      p2_q      <= hit_q ? pos_out(kc_q[AW-1:0]) : '0;
      p3_q      <= hit_q ? pos_out(kd_q[AW-1:0]) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign first_pos_o  = p0_q;
  assign second_pos_o = p1_q;
  assign third_pos_o  = p2_q;
  assign fourth_pos_o = p3_q;
  assign overflowed_o = ovf_out_q;

endmodule

[hw/rtl/fss_ram.sv]
module fss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/fss_cmp.sv]
module fss_cmp import fss_pkg::*; (
  input  logic [UW-1:0] op0_i,
  input  logic [UW-1:0] op1_i,
  input  logic [UW-1:0] op2_i,
  input  logic [UW-1:0] op3_i,
  input  logic [UW-1:0] rhs_i,
  output cmp_res_t      res_o
);

  logic [UW-1:0] sum;

  assign sum       = op0_i + op1_i + op2_i + op3_i;
  assign res_o.lt  = sum < rhs_i;
  assign res_o.eq  = sum == rhs_i;

endmodule

[hw/rtl/fss_checker.sv]
module fss_checker import fss_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               last_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               found_o,
  input logic [POS_O_W-1:0] first_pos_o,
  input logic [POS_O_W-1:0] second_pos_o,
  input logic [POS_O_W-1:0] third_pos_o,
  input logic [POS_O_W-1:0] fourth_pos_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> first_pos_o == '0 && second_pos_o == '0 &&
      third_pos_o == '0 && fourth_pos_o == '0)
    else $error("positions set without a match");

  a_hit_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> first_pos_o != second_pos_o &&
      first_pos_o != third_pos_o && first_pos_o != fourth_pos_o &&
      second_pos_o != third_pos_o && second_pos_o != fourth_pos_o &&
      third_pos_o != fourth_pos_o && first_pos_o != '0)
    else $error("match positions not distinct");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input taken during search");

endmodule

bind four_sum_index_search fss_checker u_fss_checker (.*);
